FILE: hdl/emrg_pkg.sv
// Package for the Eller maze row generator.
// Holds the channel payload types, field widths and the lane command encoding.
// Depends on nothing; the top level, the lane and the testbench refer to it.
package emrg_pkg;

   localparam int JOIN_W      = 15;
   localparam int DOWN_W      = 16;
   localparam int WALL_W      = 16;
   localparam int CFG_W       = 5;
   localparam int MIN_COLUMNS = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   typedef struct packed {
      logic [JOIN_W-1:0] join_bits;
      logic [DOWN_W-1:0] down_bits;
      logic              last_row;
   } req_type;

   typedef struct packed {
      logic [WALL_W-1:0] right_walls;
      logic [WALL_W-1:0] down_walls;
      logic              row_done_last;
   } rsp_type;

   // Command broadcast from the sequencer to every column lane.
   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_LOAD,
      LANE_MERGE,
      LANE_FLOOR,
      LANE_NUMBER,
      LANE_CLOSE
   } lane_op_type;

   typedef struct packed {
      lane_op_type op;
      logic        clear_all;
   } lane_ctl_type;

endpackage

FILE: hdl/eller_maze_row_generator.sv
// Top level of the Eller maze row generator.
// Sequencer, configuration register, output register and the column lanes.
// Depends on emrg_pkg, emrg_lane and emrg_merge.
//
// Use: each req transaction carries one maze row's random bits (join_bits,
// down_bits, last_row) and yields exactly one rsp transaction with that row's
// right walls, floors and the last-row echo. The csr channel writes the
// number of columns in use; it is always ready and should only be written
// while no row is in flight. Values below two act as two, values above
// MAX_COLUMNS as MAX_COLUMNS.
// Timing: a row runs through the accepting cycle, the merge, floor and
// renumbering passes, walked by the sequencer one column at a time, and the
// cycle that loads the output register; req_ready and the response both
// return once that register is loaded. A last row skips the floor and
// renumbering passes.
// The finished response waits in an output register, so a new row is taken
// while the previous response is still stalled; a row only waits at its end
// if the receiver has not yet taken the previous response.
// Reset clears every carried set, so the first row starts with fresh sets,
// and sets the column count to sixteen. No response is pending after reset.
module eller_maze_row_generator #(
   parameter int MAX_COLUMNS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  emrg_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output emrg_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [emrg_pkg::CFG_W-1:0]      csr_data
);

   localparam int IDX_W   = $clog2(MAX_COLUMNS);
   localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
   localparam int WORK_W  = $clog2(2 * MAX_COLUMNS);
   localparam int LABEL_W = $clog2(MAX_COLUMNS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_FLOOR,
      ST_NUMBER,
      ST_CLOSE
   } state_type;

   state_type                    state_ff, state_in;
   logic [emrg_pkg::CFG_W-1:0]   cfg_ff, cfg_in;
   logic [IDX_W-1:0]             step_ff, step_in;
   logic [IDX_W-1:0]             start_ff, start_in;
   logic                         run_any_ff, run_any_in;
   logic [LABEL_W-1:0]           next_ff, next_in;
   logic                         last_ff, last_in;
   logic [MAX_COLUMNS-1:0]       join_ff, join_in;
   logic [MAX_COLUMNS-1:0]       rw_ff, rw_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   emrg_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]             used_cols;
   logic [CNT_W-1:0]             step_p1;
   logic [MAX_COLUMNS-1:0]       used_mask;
   logic [MAX_COLUMNS-1:0]       join_vec;
   logic [MAX_COLUMNS-1:0]       down_vec;
   logic [MAX_COLUMNS-1:0]       dw_vec;
   logic [emrg_pkg::WALL_W-1:0]  rw_out, dw_out;
   logic                         accept_req, rsp_free;
   logic                         merge_end, row_end;
   logic                         is_start, is_end, cur_any;
   logic [IDX_W-1:0]             cur_start;

   emrg_pkg::lane_ctl_type       lane_ctl;
   logic [IDX_W-1:0]             force_idx;
   logic [WORK_W-1:0]            hi_label, lo_label;
   logic [LABEL_W-1:0]           new_label;

   logic [WORK_W-1:0]            lane_cur [MAX_COLUMNS];
   logic [WORK_W-1:0]            lane_nxt [MAX_COLUMNS];
   logic [WORK_W-1:0]            lane_prv [MAX_COLUMNS];
   logic [LABEL_W-1:0]           lane_hit_label [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0]       lane_cur_open, lane_open, lane_hit;

   logic [WORK_W-1:0]            cur_work, nxt_work, prv_work;
   logic                         cur_open, found;
   logic [LABEL_W-1:0]           found_label;

   // Handshakes.
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept_req = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;
   assign cfg_in     = csr_valid ? csr_data : cfg_ff;

   // Effective column count, clamped to the supported range.
   always_comb begin
      if (cfg_ff < emrg_pkg::CFG_W'(emrg_pkg::MIN_COLUMNS)) begin
         used_cols = CNT_W'(emrg_pkg::MIN_COLUMNS);
      end else if (int'(cfg_ff) > MAX_COLUMNS) begin
         used_cols = CNT_W'(MAX_COLUMNS);
      end else begin
         used_cols = CNT_W'(cfg_ff);
      end
   end

   always_comb begin
      for (int y = 0; y < MAX_COLUMNS; y++) begin
         used_mask[y] = (y < int'(used_cols));
      end
   end

   assign step_p1   = CNT_W'(step_ff) + CNT_W'(1);
   assign merge_end = (step_p1 == used_cols - CNT_W'(1));
   assign row_end   = (step_p1 == used_cols);

   // Input bits beyond the field widths read as zero; output bits beyond the
   // column count are dropped.
   for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_in_map
      if (i < emrg_pkg::JOIN_W) begin : g_join
         assign join_vec[i] = req_data.join_bits[i];
      end else begin : g_join_zero
         assign join_vec[i] = 1'b0;
      end
      if (i < emrg_pkg::DOWN_W) begin : g_down
         assign down_vec[i] = req_data.down_bits[i];
      end else begin : g_down_zero
         assign down_vec[i] = 1'b0;
      end
   end

   assign dw_vec = used_mask & ({MAX_COLUMNS{last_ff}} | ~lane_open);

   for (genvar b = 0; b < emrg_pkg::WALL_W; b++) begin : g_out_map
      if (b < MAX_COLUMNS) begin : g_bit
         assign rw_out[b] = rw_ff[b];
         assign dw_out[b] = dw_vec[b];
      end else begin : g_bit_zero
         assign rw_out[b] = 1'b0;
         assign dw_out[b] = 1'b0;
      end
   end

   // Column lanes: one per column, all fed the same broadcast command.
   for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_lane
      emrg_lane #(
         .MAX_COLUMNS (MAX_COLUMNS),
         .LANE_INDEX  (i)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl),
         .step_idx  (step_ff),
         .start_idx (force_idx),
         .used_cols (used_cols),
         .down_bit  (down_vec[i]),
         .hi_label  (hi_label),
         .lo_label  (lo_label),
         .key_label (cur_work),
         .new_label (new_label),
         .cur_work  (lane_cur[i]),
         .nxt_work  (lane_nxt[i]),
         .prv_work  (lane_prv[i]),
         .cur_open  (lane_cur_open[i]),
         .lane_open (lane_open[i]),
         .hit       (lane_hit[i]),
         .hit_label (lane_hit_label[i])
      );
   end

   emrg_merge #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_merge (
      .lane_cur       (lane_cur),
      .lane_nxt       (lane_nxt),
      .lane_prv       (lane_prv),
      .lane_cur_open  (lane_cur_open),
      .lane_hit       (lane_hit),
      .lane_hit_label (lane_hit_label),
      .cur_work       (cur_work),
      .nxt_work       (nxt_work),
      .prv_work       (prv_work),
      .cur_open       (cur_open),
      .found          (found),
      .found_label    (found_label)
   );

   // Merging keeps the smaller label, as the left-to-right scan expects.
   assign lo_label  = (cur_work < nxt_work) ? cur_work : nxt_work;
   assign hi_label  = (cur_work < nxt_work) ? nxt_work : cur_work;
   assign new_label = found ? found_label : next_ff;

   // A run starts where the label changes and ends before the next change.
   assign is_start  = (step_ff == '0) || (cur_work != prv_work);
   assign is_end    = row_end || (nxt_work != cur_work);
   assign cur_any   = is_start ? cur_open : (run_any_ff | cur_open);
   assign cur_start = is_start ? step_ff : start_ff;
   assign force_idx = cur_start;

   always_comb begin
      state_in           = state_ff;
      step_in            = step_ff;
      start_in           = start_ff;
      run_any_in         = run_any_ff;
      next_in            = next_ff;
      last_in            = last_ff;
      join_in            = join_ff;
      rw_in              = rw_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_data_in        = rsp_data_ff;
      lane_ctl.op        = emrg_pkg::LANE_IDLE;
      lane_ctl.clear_all = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               lane_ctl.op = emrg_pkg::LANE_LOAD;
               step_in     = '0;
               last_in     = req_data.last_row;
               join_in     = join_vec;
               rw_in       = '0;
               state_in    = ST_MERGE;
            end
         end
         ST_MERGE: begin
            // A last row joins every pair of different sets.
            if ((cur_work == nxt_work) || (!last_ff && !join_ff[step_ff])) begin
               rw_in[step_ff] = 1'b1;
            end else begin
               lane_ctl.op = emrg_pkg::LANE_MERGE;
            end
            if (merge_end) begin
               step_in  = '0;
               state_in = last_ff ? ST_CLOSE : ST_FLOOR;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         ST_FLOOR: begin
            start_in   = cur_start;
            run_any_in = cur_any;
            // A run with no open cell keeps its leftmost cell open.
            if (is_end && !cur_any) begin
               lane_ctl.op = emrg_pkg::LANE_FLOOR;
            end
            if (row_end) begin
               step_in  = '0;
               next_in  = '0;
               state_in = ST_NUMBER;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         ST_NUMBER: begin
            // Open cells are renumbered by first appearance from the left.
            lane_ctl.op = emrg_pkg::LANE_NUMBER;
            if (cur_open && !found) begin
               next_in = next_ff + LABEL_W'(1);
            end
            if (row_end) begin
               state_in = ST_CLOSE;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         ST_CLOSE: begin
            if (rsp_free) begin
               lane_ctl.op               = emrg_pkg::LANE_CLOSE;
               rsp_valid_in              = 1'b1;
               rsp_data_in.right_walls   = rw_out;
               rsp_data_in.down_walls    = dw_out;
               rsp_data_in.row_done_last = last_ff;
               state_in                  = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= emrg_pkg::CFG_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      step_ff     <= step_in;
      start_ff    <= start_in;
      run_any_ff  <= run_any_in;
      next_ff     <= next_in;
      last_ff     <= last_in;
      join_ff     <= join_in;
      rw_ff       <= rw_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   ap_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE || state_ff == ST_FLOOR || state_ff == ST_NUMBER)
         |-> (step_p1 <= used_cols))
      else $error("column step beyond the columns in use");

   ap_last_skips_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLOOR || state_ff == ST_NUMBER) |-> !last_ff)
      else $error("last row entered the floor or renumbering pass");

   ap_label_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NUMBER) |-> (next_ff <= step_ff))
      else $error("more labels issued than columns visited");

   ap_close_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLOSE && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished row did not reach the output register");
`endif

endmodule

FILE: hdl/emrg_lane.sv
// One column lane of the Eller maze row generator.
// Holds the column's working set label, open flag, carried tag and label.
// Depends on emrg_pkg for the lane command type.
module emrg_lane #(
   parameter int MAX_COLUMNS = 16,
   parameter int LANE_INDEX  = 0,
   localparam int IDX_W   = $clog2(MAX_COLUMNS),
   localparam int CNT_W   = $clog2(MAX_COLUMNS + 1),
   localparam int WORK_W  = $clog2(2 * MAX_COLUMNS),
   localparam int LABEL_W = $clog2(MAX_COLUMNS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  emrg_pkg::lane_ctl_type ctl,
   input  logic [IDX_W-1:0]      step_idx,
   input  logic [IDX_W-1:0]      start_idx,
   input  logic [CNT_W-1:0]      used_cols,
   input  logic                  down_bit,
   input  logic [WORK_W-1:0]     hi_label,
   input  logic [WORK_W-1:0]     lo_label,
   input  logic [WORK_W-1:0]     key_label,
   input  logic [LABEL_W-1:0]    new_label,
   output logic [WORK_W-1:0]     cur_work,
   output logic [WORK_W-1:0]     nxt_work,
   output logic [WORK_W-1:0]     prv_work,
   output logic                  cur_open,
   output logic                  lane_open,
   output logic                  hit,
   output logic [LABEL_W-1:0]    hit_label
);

   localparam logic [WORK_W-1:0] FRESH_LABEL = WORK_W'(MAX_COLUMNS + LANE_INDEX);

   logic [WORK_W-1:0]  work_ff, work_in;
   logic               open_ff, open_in;
   logic               tag_ff, tag_in;
   logic [LABEL_W-1:0] label_ff, label_in;
   logic               is_cur, is_nxt, is_prv, is_start, in_use;

   assign is_cur   = (int'(step_idx) == LANE_INDEX);
   assign is_nxt   = (int'(step_idx) + 1 == LANE_INDEX);
   assign is_prv   = (int'(step_idx) == LANE_INDEX + 1);
   assign is_start = (int'(start_idx) == LANE_INDEX);
   assign in_use   = (LANE_INDEX < int'(used_cols));

   assign cur_work  = is_cur ? work_ff : '0;
   assign nxt_work  = is_nxt ? work_ff : '0;
   assign prv_work  = is_prv ? work_ff : '0;
   assign cur_open  = is_cur & open_ff;
   assign lane_open = open_ff;
   assign hit       = open_ff && (work_ff == key_label) && (LANE_INDEX < int'(step_idx));
   assign hit_label = hit ? label_ff : '0;

   always_comb begin
      work_in  = work_ff;
      open_in  = open_ff;
      tag_in   = tag_ff;
      label_in = label_ff;
      unique case (ctl.op)
         emrg_pkg::LANE_IDLE: begin
         end
         emrg_pkg::LANE_LOAD: begin
            work_in = tag_ff ? WORK_W'(label_ff) : FRESH_LABEL;
            open_in = down_bit;
         end
         emrg_pkg::LANE_MERGE: begin
            if (work_ff == hi_label) begin
               work_in = lo_label;
            end
         end
         emrg_pkg::LANE_FLOOR: begin
            if (is_start) begin
               open_in = 1'b1;
            end
         end
         emrg_pkg::LANE_NUMBER: begin
            if (is_cur) begin
               tag_in = open_ff;
               if (open_ff) begin
                  label_in = new_label;
               end
            end
         end
         emrg_pkg::LANE_CLOSE: begin
            if (ctl.clear_all || !in_use) begin
               tag_in = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= 1'b0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      open_ff  <= open_in;
      label_ff <= label_in;
   end

endmodule

FILE: hdl/emrg_merge.sv
// Merging stage of the Eller maze row generator.
// Combines the per-lane taps and label matches into single values.
// Depends on no package; widths follow the column count parameter.
module emrg_merge #(
   parameter int MAX_COLUMNS = 16,
   localparam int WORK_W  = $clog2(2 * MAX_COLUMNS),
   localparam int LABEL_W = $clog2(MAX_COLUMNS)
) (
   input  logic [WORK_W-1:0]      lane_cur [MAX_COLUMNS],
   input  logic [WORK_W-1:0]      lane_nxt [MAX_COLUMNS],
   input  logic [WORK_W-1:0]      lane_prv [MAX_COLUMNS],
   input  logic [MAX_COLUMNS-1:0] lane_cur_open,
   input  logic [MAX_COLUMNS-1:0] lane_hit,
   input  logic [LABEL_W-1:0]     lane_hit_label [MAX_COLUMNS],
   output logic [WORK_W-1:0]      cur_work,
   output logic [WORK_W-1:0]      nxt_work,
   output logic [WORK_W-1:0]      prv_work,
   output logic                   cur_open,
   output logic                   found,
   output logic [LABEL_W-1:0]     found_label
);

   // Only one lane drives each tap, and every matching lane carries the same
   // new label, so a plain OR over the lanes selects the answer.
   always_comb begin
      cur_work    = '0;
      nxt_work    = '0;
      prv_work    = '0;
      found_label = '0;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
         cur_work    = cur_work | lane_cur[i];
         nxt_work    = nxt_work | lane_nxt[i];
         prv_work    = prv_work | lane_prv[i];
         found_label = found_label | lane_hit_label[i];
      end
   end

   assign cur_open = |lane_cur_open;
   assign found    = |lane_hit;

endmodule

FILE: sim/eller_maze_row_generator_test.sv
// Self-checking testbench for the Eller maze row generator.
// Holds a clocked driver, a clocked response checker and a row-by-row predictor.
// Depends on emrg_pkg and the eller_maze_row_generator RTL.
`timescale 1ns / 100ps

module eller_maze_row_generator_test;

   localparam int COLUMNS = 16;

   // Cycles from acceptance of a row to its response with every column in use,
   // plus some margin; used for the pauses before a register write and at the end.
   localparam int ROW_LATENCY = 3 * COLUMNS + 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   emrg_pkg::req_type             req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   emrg_pkg::rsp_type             rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [emrg_pkg::CFG_W-1:0]    csr_data  = '0;

   eller_maze_row_generator #(
      .MAX_COLUMNS(COLUMNS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Rows waiting to be offered, and the responses that accepted rows must give.
   emrg_pkg::req_type pending_rows [$];
   emrg_pkg::rsp_type predicted_rows [$];

   // Predictor state: the column count and the sets carried down from the
   // previous row. A carried label is only meaningful where the column is tagged.
   logic [emrg_pkg::CFG_W-1:0] column_setting = emrg_pkg::CFG_RESET;
   logic [3:0]                 carried_label [COLUMNS];
   bit                         carried       [COLUMNS];

   int unsigned mismatches = 0;

   initial begin
      for (int x = 0; x < COLUMNS; x++) begin
         carried_label[x] = '0;
         carried[x]       = 1'b0;
      end
   end

   // Works out the walls of one row and moves the carried sets on to the next.
   // Columns without a carried set get labels above every carried one, so a
   // merge that keeps the smaller label never collides with a carried set.
   function automatic emrg_pkg::rsp_type carve_row(emrg_pkg::req_type row);
      int unsigned       used;
      int unsigned       set_id [COLUMNS];
      bit                open_cell [COLUMNS];
      int unsigned       lo, hi, run_end, next_label;
      int                x, y;
      bit                any_open, found;
      emrg_pkg::rsp_type walls;

      used = column_setting;
      if (used < emrg_pkg::MIN_COLUMNS) used = emrg_pkg::MIN_COLUMNS;
      if (used > COLUMNS) used = COLUMNS;
      walls = '0;
      walls.row_done_last = row.last_row;

      for (x = 0; x < used; x++)
         set_id[x] = carried[x] ? carried_label[x] : COLUMNS + x;

      // Left to right: wall off neighbours in one set, or those the join bit
      // keeps apart; otherwise merge the two sets into the smaller label.
      for (x = 0; x + 1 < used; x++) begin
         if (set_id[x] == set_id[x + 1] || (!row.last_row && !row.join_bits[x])) begin
            walls.right_walls[x] = 1'b1;
         end else begin
            lo = (set_id[x] < set_id[x + 1]) ? set_id[x] : set_id[x + 1];
            hi = (set_id[x] < set_id[x + 1]) ? set_id[x + 1] : set_id[x];
            for (y = 0; y < used; y++)
               if (set_id[y] == hi) set_id[y] = lo;
         end
      end

      if (row.last_row) begin
         for (x = 0; x < used; x++) walls.down_walls[x] = 1'b1;
         for (x = 0; x < COLUMNS; x++) begin
            carried[x]       = 1'b0;
            carried_label[x] = '0;
         end
         return walls;
      end

      // Each contiguous run of one set keeps at least one cell open below.
      x = 0;
      while (x < used) begin
         run_end  = x;
         any_open = 1'b0;
         while (run_end + 1 < used && set_id[run_end + 1] == set_id[x]) run_end++;
         for (y = x; y <= run_end; y++) begin
            open_cell[y] = row.down_bits[y];
            if (open_cell[y]) any_open = 1'b1;
         end
         if (!any_open) open_cell[x] = 1'b1;
         for (y = x; y <= run_end; y++)
            if (!open_cell[y]) walls.down_walls[y] = 1'b1;
         x = run_end + 1;
      end

      // Open cells carry their set down, renumbered in order of first appearance.
      next_label = 0;
      for (x = 0; x < used; x++) begin
         if (!open_cell[x]) begin
            carried[x]       = 1'b0;
            carried_label[x] = '0;
         end else begin
            found = 1'b0;
            for (y = 0; y < x && !found; y++) begin
               if (open_cell[y] && set_id[y] == set_id[x]) begin
                  carried_label[x] = carried_label[y];
                  found = 1'b1;
               end
            end
            if (!found) begin
               carried_label[x] = next_label[3:0];
               next_label++;
            end
            carried[x] = 1'b1;
         end
      end
      for (x = used; x < COLUMNS; x++) begin
         carried[x]       = 1'b0;
         carried_label[x] = '0;
      end
      return walls;
   endfunction

   // Driver. The sender works in bursts separated by gaps; while a row is on
   // offer and not yet taken it is held unchanged. When a transaction completes,
   // its expected response is predicted straight away.
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predicted_rows.insert(predicted_rows.size(), carve_row(req_data));
         end
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_rows.size() != 0) begin
            req_data  <= pending_rows.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               // Pick the shape of the next burst: sometimes a long run with no
               // gaps at all, otherwise short bursts with gaps of varied length so
               // that rows arrive at every point of the block's column walk.
               case ($urandom_range(0, 3))
                  0: begin
                     gap_left   = 0;
                     burst_left = $urandom_range(20, 80);
                  end
                  1: begin
                     gap_left   = $urandom_range(1, 3);
                     burst_left = $urandom_range(1, 8);
                  end
                  2: begin
                     gap_left   = $urandom_range(5, 30);
                     burst_left = $urandom_range(1, 8);
                  end
                  default: begin
                     gap_left   = $urandom_range(40, 70);
                     burst_left = $urandom_range(1, 4);
                  end
               endcase
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response checker. The receiver stalls on a pattern chosen by bits 9:8 of the
   // tick counter, and now and then holds off for a long stretch so that the
   // output register fills and the block has to refuse further rows.
   emrg_pkg::rsp_type wanted_row;
   int unsigned       rows_seen    = 0;
   int unsigned       tick         = 0;
   int unsigned       hold_left    = 0;
   int unsigned       next_hold_at = 200;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         tick <= tick + 1;
         if (rsp_valid && rsp_ready) begin
            rows_seen <= rows_seen + 1;
            if (predicted_rows.size() == 0) begin
               $display("%0t: response with no row outstanding, expected nothing, got %p",
                        $time, rsp_data);
               mismatches++;
            end else begin
               wanted_row = predicted_rows.pop_front();
               if (rsp_data.right_walls !== wanted_row.right_walls) begin
                  $display("%0t: right_walls expected %h, got %h",
                           $time, wanted_row.right_walls, rsp_data.right_walls);
                  mismatches++;
               end
               if (rsp_data.down_walls !== wanted_row.down_walls) begin
                  $display("%0t: down_walls expected %h, got %h",
                           $time, wanted_row.down_walls, rsp_data.down_walls);
                  mismatches++;
               end
               if (rsp_data.row_done_last !== wanted_row.row_done_last) begin
                  $display("%0t: row_done_last expected %b, got %b",
                           $time, wanted_row.row_done_last, rsp_data.row_done_last);
                  mismatches++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rows_seen >= next_hold_at) begin
            hold_left    <= 400;
            next_hold_at <= next_hold_at + 650;
            rsp_ready    <= 1'b0;
         end else begin
            case (tick[9:8])
               2'd0:    rsp_ready <= 1'b1;
               2'd1:    rsp_ready <= ($urandom_range(0, 3) != 0);
               2'd2:    rsp_ready <= ($urandom_range(0, 2) == 0);
               default: rsp_ready <= tick[2];
            endcase
         end
      end
   end

   // Returns once every queued row has been taken and every response checked.
   task automatic wait_for_quiet();
      while (pending_rows.size() != 0 || req_valid || predicted_rows.size() != 0)
         @(posedge clock);
   endtask

   // Writes the column count while the block is idle. The model picks up the
   // new value at the edge where the transaction completes.
   task automatic write_columns(logic [emrg_pkg::CFG_W-1:0] value);
      wait_for_quiet();
      repeat (ROW_LATENCY) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      column_setting = value;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_row(int unsigned join_mask, int unsigned down_mask, bit last);
      emrg_pkg::req_type row;
      row.join_bits = join_mask[emrg_pkg::JOIN_W-1:0];
      row.down_bits = down_mask[emrg_pkg::DOWN_W-1:0];
      row.last_row  = last;
      pending_rows.insert(pending_rows.size(), row);
   endtask

   // Random mazes: a few rows of random bits closed by a last row, with some
   // rows pushed to the extremes and the odd stray last row in between.
   task automatic queue_mazes(int unsigned rows);
      int unsigned       height, h;
      emrg_pkg::req_type row;
      while (rows != 0) begin
         height = $urandom_range(1, 10);
         for (h = 0; h < height && rows != 0; h++) begin
            row.join_bits = emrg_pkg::JOIN_W'($urandom_range(0, 2**emrg_pkg::JOIN_W - 1));
            row.down_bits = emrg_pkg::DOWN_W'($urandom_range(0, 2**emrg_pkg::DOWN_W - 1));
            case ($urandom_range(0, 11))
               0:       row.join_bits = '0;
               1:       row.join_bits = '1;
               2:       row.down_bits = '0;
               3:       row.down_bits = '1;
               4:       row.down_bits = emrg_pkg::DOWN_W'(1)
                                        << $urandom_range(0, emrg_pkg::DOWN_W - 1);
               default: ;
            endcase
            row.last_row = (h == height - 1) || ($urandom_range(0, 39) == 0);
            pending_rows.insert(pending_rows.size(), row);
            rows--;
         end
      end
   endtask

   // Column counts for the random phases, the out-of-range ones among them.
   logic [emrg_pkg::CFG_W-1:0] phase_columns [12] = '{5'd2, 5'd31, 5'd0, 5'd1, 5'd17,
                                                       5'd16, 5'd3, 5'd9, 5'd0, 5'd0,
                                                       5'd15, 5'd16};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows at the reset width of sixteen columns.
      queue_row(16'h0000, 16'h0000, 1'b0);  // all walls, lone sets, no down bits
      queue_row(16'h7FFF, 16'hFFFF, 1'b0);  // joins everywhere, all cells open
      queue_row(16'h7FFF, 16'h0000, 1'b0);  // one run, only leftmost stays open
      queue_row(16'h5555, 16'hAAAA, 1'b0);
      queue_row(16'h2AAA, 16'h5555, 1'b0);
      queue_row(16'h0000, 16'h0000, 1'b1);  // last row joins despite zero joins
      queue_row(16'h0000, 16'hFFFF, 1'b0);  // fresh sets after the maze ended
      queue_row(16'h0000, 16'hFFFF, 1'b0);  // carried sets, no joins
      queue_row(16'h7FFF, 16'hFFFF, 1'b1);  // last row with every join bit set
      queue_row(16'h7FFF, 16'h8001, 1'b0);
      queue_row(16'h4001, 16'h0001, 1'b0);
      queue_row(16'h0F0F, 16'h7FFE, 1'b0);
      queue_row(16'h3C3C, 16'h0000, 1'b0);
      queue_row(16'h0000, 16'h0000, 1'b1);

      foreach (phase_columns[p]) begin
         if (p == 8 || p == 9)
            write_columns(emrg_pkg::CFG_W'($urandom_range(emrg_pkg::MIN_COLUMNS, COLUMNS)));
         else
            write_columns(phase_columns[p]);
         @(negedge clock);
         queue_mazes(130);
      end

      wait_for_quiet();
      repeat (ROW_LATENCY) @(posedge clock);
      if (mismatches == 0) begin
         $display("eller_maze_row_generator_test OK");
      end else begin
         $display("eller_maze_row_generator_test NOT OK");
      end
      $finish;
   end

   // Watchdog: a correct run finishes well inside this time.
   initial begin
      #4000000;
      $display("eller_maze_row_generator_test NOT OK");
      $finish;
   end

endmodule

FILE: sim.f
hdl/emrg_pkg.sv
hdl/emrg_lane.sv
hdl/emrg_merge.sv
hdl/eller_maze_row_generator.sv
sim/eller_maze_row_generator_test.sv
